// ===== sv/thm_pkg.sv =====
`timescale 1ns / 1ps
package thm_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int CACHE_DEF     = 1024;

    localparam int CFG_W      = 17;
    localparam int SIDE_CFG_W = 9;
    localparam int QUOT_W     = 32;
    localparam int DIVR_W     = 17;
    localparam int DVD_W      = QUOT_W + DIVR_W;
    localparam int EPOCH_W    = 8;
    localparam int CELL_W     = 32;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_DECAY = 2'd1;
    localparam logic [1:0] OP_CLEAN = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOG   = 2'd1;
    localparam logic [1:0] ST_NOBIN = 2'd2;

    localparam logic [1:0] CFG_BIN   = 2'd0;
    localparam logic [1:0] CFG_DECAY = 2'd1;
    localparam logic [1:0] CFG_SIDE  = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_start;
        logic div_dec;
        logic bin_eval;
        logic i_clr;
        logic i_inc;
        logic w_inc;
        logic cache_rd;
        logic lk_hit;
        logic lk_miss;
        logic addr_load;
        logic addr_key;
        logic cell_rd;
        logic cell_wr;
        logic evt_inc;
        logic dec_chk;
        logic dec_mul;
        logic keep_wr;
        logic cnt_set;
        logic set_oog;
        logic set_nobin;
        logic out_load;
    } thm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       div_done;
        logic       wrap;
        logic       scan_end;
        logic       hit;
        logic       oog;
        logic       bin_open;
        logic       skip;
        logic       keep;
        logic       out_free;
    } thm_st_t;

endpackage

// ===== sv/thm_div.sv =====
`timescale 1ns / 1ps
module thm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [thm_pkg::DVD_W-1:0]    dividend,
    input  logic [thm_pkg::DIVR_W-1:0]   divisor,
    output logic                         done,
    output logic [thm_pkg::QUOT_W-1:0]   quot,
    output logic [thm_pkg::DIVR_W-1:0]   rem
);
    import thm_pkg::*;

    localparam int CW = $clog2(QUOT_W + 1);

    logic [DIVR_W-1:0] rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   shifted;
    logic [DIVR_W+1:0] diff;
    logic              ge;

    // quotient must fit QUOT_W bits: upper dividend bits stay below the divisor
    assign shifted = {rem_reg, q_reg[QUOT_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, dvs_reg};
    assign ge      = ~diff[DIVR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(QUOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DVD_W-1:QUOT_W];
            q_reg   <= dividend[QUOT_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            q_reg   <= {q_reg[QUOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;
endmodule

// ===== sv/thm_ctrl.sv =====
`timescale 1ns / 1ps
module thm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  thm_pkg::thm_st_t  st,
    output thm_pkg::thm_cmd_t cmd
);
    import thm_pkg::*;

    localparam logic [4:0] S_RCLR = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISP = 5'd2;
    localparam logic [4:0] S_BDS  = 5'd3;
    localparam logic [4:0] S_BDW  = 5'd4;
    localparam logic [4:0] S_BIN  = 5'd5;
    localparam logic [4:0] S_WCLR = 5'd6;
    localparam logic [4:0] S_LRD  = 5'd7;
    localparam logic [4:0] S_LCMP = 5'd8;
    localparam logic [4:0] S_LMIS = 5'd9;
    localparam logic [4:0] S_CELL = 5'd10;
    localparam logic [4:0] S_CRD  = 5'd11;
    localparam logic [4:0] S_CWR  = 5'd12;
    localparam logic [4:0] S_DRD  = 5'd13;
    localparam logic [4:0] S_DCHK = 5'd14;
    localparam logic [4:0] S_DMUL = 5'd15;
    localparam logic [4:0] S_DDS  = 5'd16;
    localparam logic [4:0] S_DDW  = 5'd17;
    localparam logic [4:0] S_KRD  = 5'd18;
    localparam logic [4:0] S_KCHK = 5'd19;
    localparam logic [4:0] S_DONE = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RCLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_RCLR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.i_clr = 1'b1;
                case (st.op)
                    OP_EVENT: state_next = S_BDS;
                    OP_DECAY: begin
                        if (st.bin_open) begin
                            state_next = S_DRD;
                        end else begin
                            cmd.set_nobin = 1'b1;
                            state_next    = S_DONE;
                        end
                    end
                    OP_CLEAN: state_next = S_KRD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_BDS: begin
                cmd.div_start = 1'b1;
                state_next    = S_BDW;
            end
            S_BDW: begin
                if (st.div_done) state_next = S_BIN;
            end
            S_BIN: begin
                cmd.bin_eval = 1'b1;
                state_next   = st.wrap ? S_WCLR : S_LRD;
            end
            S_WCLR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) state_next = S_LRD;
            end
            S_LRD: begin
                if (st.scan_end) begin
                    state_next = S_LMIS;
                end else begin
                    cmd.cache_rd = 1'b1;
                    state_next   = S_LCMP;
                end
            end
            S_LCMP: begin
                if (st.hit) begin
                    cmd.lk_hit = 1'b1;
                    state_next = S_CELL;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_LRD;
                end
            end
            S_LMIS: begin
                cmd.lk_miss = 1'b1;
                state_next  = S_CELL;
            end
            S_CELL: begin
                if (st.oog) begin
                    cmd.set_oog = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.addr_load = 1'b1;
                    state_next    = S_CRD;
                end
            end
            S_CRD: begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CWR;
            end
            S_CWR: begin
                cmd.cell_wr = 1'b1;
                if (st.op == OP_EVENT) begin
                    cmd.evt_inc = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_DRD;
                end
            end
            S_DRD: begin
                if (st.scan_end) begin
                    state_next = S_DONE;
                end else begin
                    cmd.cache_rd = 1'b1;
                    state_next   = S_DCHK;
                end
            end
            S_DCHK: begin
                if (st.skip) begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_DRD;
                end else begin
                    cmd.dec_chk   = 1'b1;
                    cmd.addr_load = 1'b1;
                    cmd.addr_key  = 1'b1;
                    state_next    = S_DMUL;
                end
            end
            S_DMUL: begin
                cmd.dec_mul = 1'b1;
                state_next  = S_DDS;
            end
            S_DDS: begin
                cmd.div_start = 1'b1;
                cmd.div_dec   = 1'b1;
                state_next    = S_DDW;
            end
            S_DDW: begin
                if (st.div_done) state_next = S_CRD;
            end
            S_KRD: begin
                if (st.scan_end) begin
                    cmd.cnt_set = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.cache_rd = 1'b1;
                    state_next   = S_KCHK;
                end
            end
            S_KCHK: begin
                cmd.i_inc = 1'b1;
                if (st.keep) begin
                    cmd.keep_wr = 1'b1;
                    cmd.w_inc   = 1'b1;
                end
                state_next = S_KRD;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== sv/thm_dp.sv =====
`timescale 1ns / 1ps
module thm_dp #(
    parameter int GRID_SIDE     = thm_pkg::GRID_SIDE_DEF,
    parameter int CACHE_ENTRIES = thm_pkg::CACHE_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  thm_pkg::thm_cmd_t                     cmd,
    output thm_pkg::thm_st_t                      st,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [thm_pkg::CFG_W-1:0]             cfg_data,
    input  logic [1:0]                            s_opcode,
    input  logic [31:0]                           s_stamp,
    input  logic [15:0]                           s_x_coord,
    input  logic [15:0]                           s_y_coord,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic                                  m_bin_closed,
    output logic [31:0]                           m_closed_bin_start,
    output logic [31:0]                           m_closed_event_count,
    output logic [16:0]                           m_closed_unique_cells,
    output logic [31:0]                           m_closed_max_intensity,
    output logic [31:0]                           m_current_max_intensity,
    output logic [$clog2(CACHE_ENTRIES+1)-1:0]    m_cache_entries,
    output logic                                  m_cache_insert_dropped
);
    import thm_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CAW   = $clog2(CELLS);
    localparam int SW    = $clog2(GRID_SIDE + 1);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int CIW   = $clog2(CACHE_ENTRIES);
    localparam int HW    = EPOCH_W + CELL_W;
    localparam int EW    = 96;

    // configuration
    logic [CFG_W-1:0]      bin_len_reg;
    logic [CFG_W-1:0]      decay_reg;
    logic [SIDE_CFG_W-1:0] side_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_len_reg  <= CFG_W'(60);
            decay_reg    <= CFG_W'(300);
            side_cfg_reg <= SIDE_CFG_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BIN:   bin_len_reg  <= cfg_data;
                CFG_DECAY: decay_reg    <= cfg_data;
                CFG_SIDE:  side_cfg_reg <= cfg_data[SIDE_CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [CFG_W-1:0] bl_eff;
    logic [CFG_W-1:0] d_eff;
    logic [31:0]      side_cfg32;
    logic [SW-1:0]    side_clamp;

    assign bl_eff     = (bin_len_reg == '0) ? CFG_W'(1) : bin_len_reg;
    assign d_eff      = (decay_reg == '0) ? CFG_W'(1) : decay_reg;
    assign side_cfg32 = 32'(side_cfg_reg);
    assign side_clamp = (side_cfg32 == 32'd0) ? SW'(1) :
                        (side_cfg32 > 32'(GRID_SIDE)) ? SW'(GRID_SIDE) : SW'(side_cfg32);

    // input beat
    logic [1:0]  op_reg;
    logic [31:0] t_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_opcode;
            t_reg  <= s_stamp;
            x_reg  <= s_x_coord;
            y_reg  <= s_y_coord;
        end
    end

    // divider
    logic [DVD_W-1:0]  div_dvd;
    logic [DIVR_W-1:0] div_dvs;
    logic              div_done;
    logic [QUOT_W-1:0] div_q;
    logic [DIVR_W-1:0] div_r;
    logic [DVD_W-1:0]  prod_reg;

    assign div_dvd = cmd.div_dec ? prod_reg : {{DIVR_W{1'b0}}, t_reg};
    assign div_dvs = cmd.div_dec ? d_eff : bl_eff;

    thm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // open bin
    logic               bin_open_reg;
    logic [31:0]        open_start_reg;
    logic [31:0]        open_count_reg;
    logic [31:0]        open_max_reg;
    logic [16:0]        open_cells_reg;
    logic [SW-1:0]      side_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    logic [31:0] bin_base;
    logic        rollover;

    assign bin_base = t_reg - 32'(div_r);
    assign rollover = !bin_open_reg || (bin_base != open_start_reg);

    // scan counters
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] w_reg;

    // recency cache: {key, seen time, intensity}
    logic [EW-1:0] cache_mem [CACHE_ENTRIES];
    logic [EW-1:0] crd_reg;
    logic [31:0]   rd_key;
    logic [31:0]   rd_last;
    logic [31:0]   rd_int;
    logic          cwe;
    logic [CIW-1:0] cwa;
    logic [EW-1:0] cwd;
    logic          full;

    assign rd_key  = crd_reg[95:64];
    assign rd_last = crd_reg[63:32];
    assign rd_int  = crd_reg[31:0];
    assign full    = (cnt_reg >= CNT_W'(CACHE_ENTRIES));

    always_comb begin
        cwe = 1'b0;
        cwa = i_reg[CIW-1:0];
        cwd = crd_reg;
        if (cmd.lk_hit) begin
            cwe = 1'b1;
            cwd = {rd_key, t_reg, (&rd_int) ? rd_int : rd_int + 32'd1};
        end else if (cmd.lk_miss && !full) begin
            cwe = 1'b1;
            cwa = cnt_reg[CIW-1:0];
            cwd = {x_reg, y_reg, t_reg, 32'd1};
        end else if (cmd.keep_wr) begin
            cwe = 1'b1;
            cwa = w_reg[CIW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cwe) cache_mem[cwa] <= cwd;
        if (cmd.cache_rd) crd_reg <= cache_mem[i_reg[CIW-1:0]];
    end

    // age tests against the entry just read
    logic [32:0] dec_diff;
    logic [32:0] cln_diff;
    logic        key_oog;
    logic        dec_skip;
    logic        cln_keep;

    assign dec_diff = {1'b0, open_start_reg} - {1'b0, rd_last};
    assign cln_diff = {1'b0, t_reg} - {1'b0, rd_last};
    assign key_oog  = (rd_key[31:16] >= 16'(side_reg)) || (rd_key[15:0] >= 16'(side_reg));
    assign dec_skip = dec_diff[32] || (dec_diff[31:0] > 32'(d_eff)) || key_oog;
    assign cln_keep = !cln_diff[32] && (cln_diff[31:0] <= 32'(d_eff));

    logic [CFG_W-1:0] dma_reg;
    logic             min1_reg;
    logic [31:0]      dint_reg;

    always_ff @(posedge aclk) begin
        if (cmd.dec_chk) begin
            dma_reg  <= d_eff - dec_diff[CFG_W-1:0];
            min1_reg <= (dec_diff[31:0] != 32'(d_eff));
            dint_reg <= rd_int;
        end
        if (cmd.dec_mul) prod_reg <= dint_reg * dma_reg;
    end

    // heat grid with epoch tags
    logic [HW-1:0]  heat_mem [CELLS];
    logic [HW-1:0]  hrd_reg;
    logic [CAW-1:0] addr_reg;
    logic [CAW-1:0] clr_reg;
    logic           clr_last;
    logic [15:0]    ax;
    logic [15:0]    ay;
    logic           evt_oog;

    assign clr_last = (clr_reg == CAW'(CELLS - 1));
    assign ax       = cmd.addr_key ? rd_key[31:16] : x_reg;
    assign ay       = cmd.addr_key ? rd_key[15:0] : y_reg;
    assign evt_oog  = (x_reg >= 16'(side_reg)) || (y_reg >= 16'(side_reg));

    always_ff @(posedge aclk) begin
        if (cmd.addr_load) addr_reg <= CAW'(ay) * CAW'(side_reg) + CAW'(ax);
    end

    logic [31:0] old_val;
    logic [31:0] amt;
    logic [32:0] sum;
    logic [31:0] new_val;

    assign old_val = (hrd_reg[HW-1:CELL_W] == epoch_reg) ? hrd_reg[CELL_W-1:0] : 32'd0;
    assign amt     = (op_reg == OP_EVENT) ? 32'd1 :
                     ((div_q == 32'd0) && min1_reg) ? 32'd1 : div_q;
    assign sum     = {1'b0, old_val} + {1'b0, amt};
    assign new_val = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            heat_mem[clr_reg] <= '0;
        end else if (cmd.cell_wr) begin
            heat_mem[addr_reg] <= {epoch_reg, new_val};
        end
        if (cmd.cell_rd) hrd_reg <= heat_mem[addr_reg];
    end

    // results
    logic        valid_reg;
    logic [1:0]  stat_reg;
    logic        closed_reg;
    logic [31:0] c_start_reg;
    logic [31:0] c_count_reg;
    logic [16:0] c_cells_reg;
    logic [31:0] c_max_reg;
    logic        drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_open_reg   <= 1'b0;
            open_start_reg <= '0;
            open_count_reg <= '0;
            open_max_reg   <= '0;
            open_cells_reg <= '0;
            side_reg       <= SW'(1);
            epoch_reg      <= '0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            clr_reg        <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_reg <= clr_last ? '0 : clr_reg + CAW'(1);
            if (cmd.bin_eval && rollover) begin
                bin_open_reg   <= 1'b1;
                open_start_reg <= bin_base;
                open_count_reg <= '0;
                open_max_reg   <= '0;
                open_cells_reg <= '0;
                side_reg       <= side_clamp;
                epoch_reg      <= epoch_reg + EPOCH_W'(1);
            end
            if (cmd.cell_wr) begin
                if (old_val == 32'd0 && new_val != 32'd0 && !(&open_cells_reg))
                    open_cells_reg <= open_cells_reg + 17'd1;
                if (new_val > open_max_reg) open_max_reg <= new_val;
            end
            if (cmd.evt_inc && !(&open_count_reg)) open_count_reg <= open_count_reg + 32'd1;
            if (cmd.lk_miss && !full) cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.cnt_set) cnt_reg <= w_reg;
            if (cmd.i_clr) begin
                i_reg <= '0;
                w_reg <= '0;
            end else begin
                if (cmd.i_inc) i_reg <= i_reg + CNT_W'(1);
                if (cmd.w_inc) w_reg <= w_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            stat_reg    <= ST_OK;
            closed_reg  <= 1'b0;
            c_start_reg <= '0;
            c_count_reg <= '0;
            c_cells_reg <= '0;
            c_max_reg   <= '0;
            drop_reg    <= 1'b0;
        end else begin
            if (cmd.set_oog) stat_reg <= ST_OOG;
            if (cmd.set_nobin) stat_reg <= ST_NOBIN;
            if (cmd.lk_miss && full) drop_reg <= 1'b1;
            if (cmd.bin_eval && rollover && bin_open_reg) begin
                closed_reg  <= 1'b1;
                c_start_reg <= open_start_reg;
                c_count_reg <= open_count_reg;
                c_cells_reg <= open_cells_reg;
                c_max_reg   <= open_max_reg;
            end
        end
    end

    logic [1:0]       o_stat_reg;
    logic             o_closed_reg;
    logic [31:0]      o_start_reg;
    logic [31:0]      o_count_reg;
    logic [16:0]      o_cells_reg;
    logic [31:0]      o_cmax_reg;
    logic [31:0]      o_max_reg;
    logic [CNT_W-1:0] o_cnt_reg;
    logic             o_drop_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_stat_reg   <= stat_reg;
            o_closed_reg <= closed_reg;
            o_start_reg  <= c_start_reg;
            o_count_reg  <= c_count_reg;
            o_cells_reg  <= c_cells_reg;
            o_cmax_reg   <= c_max_reg;
            o_max_reg    <= bin_open_reg ? open_max_reg : 32'd0;
            o_cnt_reg    <= cnt_reg;
            o_drop_reg   <= drop_reg;
        end
    end

    assign m_valid                 = valid_reg;
    assign m_status                = o_stat_reg;
    assign m_bin_closed            = o_closed_reg;
    assign m_closed_bin_start      = o_start_reg;
    assign m_closed_event_count    = o_count_reg;
    assign m_closed_unique_cells   = o_cells_reg;
    assign m_closed_max_intensity  = o_cmax_reg;
    assign m_current_max_intensity = o_max_reg;
    assign m_cache_entries         = o_cnt_reg;
    assign m_cache_insert_dropped  = o_drop_reg;

    always_comb begin
        st          = '0;
        st.op       = op_reg;
        st.clr_last = clr_last;
        st.div_done = div_done;
        st.wrap     = rollover && (&epoch_reg);
        st.scan_end = (i_reg == cnt_reg);
        st.hit      = (rd_key == {x_reg, y_reg});
        st.oog      = evt_oog;
        st.bin_open = bin_open_reg;
        st.skip     = dec_skip;
        st.keep     = cln_keep;
        st.out_free = !valid_reg || m_ready;
    end
endmodule

// ===== sv/time_binned_heatmap_with_decay_cache.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    opcode, stamp, x_coord, y_coord
// m_        out        m_valid / m_ready    status ... cache_insert_dropped
// cfg_      in         cfg_we (no wait)     cfg_index, cfg_data
//
// Add event: the serial divider finds the bin start, then the cached entries are
// scanned. Decay: skipped entries are passed over; each applied entry goes through
// the serial divider. Clean: one pass over the entries. One item in flight at a time.
// Reset starts a clear of all GRID_SIDE*GRID_SIDE grid cells; the same clear runs
// after every 256th bin change (epoch tag wrap). s_ready is low meanwhile.
// A waiting result beat does not block the next item, only its own result.
module time_binned_heatmap_with_decay_cache #(
    parameter int GRID_SIDE     = thm_pkg::GRID_SIDE_DEF,
    parameter int CACHE_ENTRIES = thm_pkg::CACHE_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [thm_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_opcode,
    input  logic [31:0]                           s_stamp,
    input  logic [15:0]                           s_x_coord,
    input  logic [15:0]                           s_y_coord,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic                                  m_bin_closed,
    output logic [31:0]                           m_closed_bin_start,
    output logic [31:0]                           m_closed_event_count,
    output logic [16:0]                           m_closed_unique_cells,
    output logic [31:0]                           m_closed_max_intensity,
    output logic [31:0]                           m_current_max_intensity,
    output logic [$clog2(CACHE_ENTRIES+1)-1:0]    m_cache_entries,
    output logic                                  m_cache_insert_dropped
);
    import thm_pkg::*;

    thm_cmd_t cmd;
    thm_st_t  st;

    thm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    thm_dp #(
        .GRID_SIDE     (GRID_SIDE),
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .st                      (st),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .s_opcode                (s_opcode),
        .s_stamp                 (s_stamp),
        .s_x_coord               (s_x_coord),
        .s_y_coord               (s_y_coord),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_status                (m_status),
        .m_bin_closed            (m_bin_closed),
        .m_closed_bin_start      (m_closed_bin_start),
        .m_closed_event_count    (m_closed_event_count),
        .m_closed_unique_cells   (m_closed_unique_cells),
        .m_closed_max_intensity  (m_closed_max_intensity),
        .m_current_max_intensity (m_current_max_intensity),
        .m_cache_entries         (m_cache_entries),
        .m_cache_insert_dropped  (m_cache_insert_dropped)
    );
endmodule

// ===== sv/thm_chk.sv =====
`timescale 1ns / 1ps
module thm_chk #(
    parameter int CACHE_ENTRIES = thm_pkg::CACHE_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic                               m_bin_closed,
    input logic [31:0]                        m_current_max_intensity,
    input logic [$clog2(CACHE_ENTRIES+1)-1:0] m_cache_entries
);
    import thm_pkg::*;

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_cache_entries))
        else $error("result beat changed while stalled");

    a_close_evt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bin_closed |-> m_status != ST_NOBIN)
        else $error("bin closed by a non-event beat");

    a_nobin_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NOBIN |-> m_current_max_intensity == 32'd0)
        else $error("max reported with no open bin");

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cache_entries <= CNT_W'(CACHE_ENTRIES))
        else $error("cache count above capacity");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind time_binned_heatmap_with_decay_cache thm_chk #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
) u_thm_chk (.*);
